[sv/double_hash_set_engine_defines.svh]
// Assertion macros for the double hash set engine
`ifndef DOUBLE_HASH_SET_ENGINE_DEFINES_SVH
`define DOUBLE_HASH_SET_ENGINE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define DHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhs check failed");

// Next-cycle implication, held off during reset
`define DHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhs check failed");

`endif

[sv/dhs_pkg.sv]
package dhs_pkg;

    // Command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // One table slot
    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  len;
        logic        occ;
        logic        live;
    } slot_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_cmd;
        logic load_ckey;
        logic load_rkey;
        logic hash;
        logic slot_rd_pos;
        logic slot_rd_idx;
        logic advance;
        logic wr_new;
        logic wr_dead;
        logic wr_clear_idx;
        logic copy_wr;
        logic rh_rd;
        logic idx_clr;
        logic idx_inc;
        logic grow_size;
        logic inc_active;
        logic dec_active;
        logic res_set;
        logic res_ok;
        logic res_full;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       occ;
        logic       live;
        logic       match;
        logic       probe_last;
        logic       need_grow;
        logic       can_grow;
        logic       idx_last_all;
        logic       idx_last_size;
        logic       idx_last_half;
        logic       rh_live;
    } sts_t;

endpackage

[sv/double_hash_set_engine.sv]
// Find, remove and add hash the key, then read and check one probed slot after another.
// An add that uses all probes re-reads its start slot. An unknown op or a rejected add ends
// at the decision. A growing add copies every old slot, then re-inserts each live old slot
// and skips the others. Throughput: one command at a time; the next start is taken in the cycle
// done is shown. Results are strobed on done; the receiver cannot stall.
// Reset: async active low; a clearing pass holds busy high after it.
module double_hash_set_engine #(
    parameter int MAX_SLOTS     = 1024,
    parameter int INITIAL_SLOTS = 8,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [63:0] key_bytes,
    input  logic [3:0]  key_length,
    output logic        done,
    output logic        success,
    output logic        table_full,
    output logic [10:0] live_count,
    output logic [10:0] slots_in_use
);
    dhs_pkg::ctl_t ctl;
    dhs_pkg::sts_t sts;

    // Sequencer
    dhs_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Table, hashing and counters
    dhs_datapath #(
        .MAX_SLOTS     (MAX_SLOTS),
        .INITIAL_SLOTS (INITIAL_SLOTS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cmd          (cmd),
        .key_bytes    (key_bytes),
        .key_length   (key_length),
        .done         (done),
        .success      (success),
        .table_full   (table_full),
        .live_count   (live_count),
        .slots_in_use (slots_in_use)
    );

endmodule

[sv/dhs_datapath.sv]
module dhs_datapath #(
    parameter int MAX_SLOTS     = 1024,
    parameter int INITIAL_SLOTS = 8,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dhs_pkg::ctl_t ctl,
    output dhs_pkg::sts_t sts,
    input  logic [1:0]    cmd,
    input  logic [63:0]   key_bytes,
    input  logic [3:0]    key_length,
    output logic          done,
    output logic          success,
    output logic          table_full,
    output logic [10:0]   live_count,
    output logic [10:0]   slots_in_use
);
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = AW + 1;

    // Memories
    dhs_pkg::slot_t slot_mem [MAX_SLOTS];
    dhs_pkg::slot_t rh_mem   [MAX_SLOTS];
    dhs_pkg::slot_t slot_q_reg;
    dhs_pkg::slot_t rh_q_reg;

    // Key and probe registers
    logic [1:0]    cmd_reg;
    logic [63:0]   wkey_bytes_reg, ckey_bytes_reg;
    logic [3:0]    wkey_len_reg, ckey_len_reg;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] step_reg, step_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] size_reg;
    logic [CW-1:0] active_reg;
    logic          done_reg, ok_reg, full_reg;

    logic [3:0]    len_sat;
    logic [63:0]   bytes_masked;
    logic [AW-1:0] mask;
    logic [AW-1:0] h1, h2, bx;

    // Input key trimming
    always_comb
    begin
        len_sat = (key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length;
        bytes_masked = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < len_sat)
            begin
                bytes_masked[8*i +: 8] = key_bytes[8*i +: 8];
            end
        end
    end

    // Horner hashes; multipliers size-1 and size+1 reduce to negate and identity
    always_comb
    begin
        mask = AW'(size_reg - CW'(1));
        h1 = '0;
        h2 = '0;
        bx = '0;
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            bx = AW'(wkey_bytes_reg[8*i +: 8]);
            if (4'(i) < wkey_len_reg)
            begin
                h1 = (bx - h1) & mask;
                h2 = (h2 + bx) & mask;
            end
        end
        pos_next  = {h1[AW-2:0], 1'b1} & mask;
        step_next = {h2[AW-2:0], 1'b1} & mask;
    end

    // Slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_new)
        begin
            slot_mem[pos_reg] <= '{bytes: wkey_bytes_reg, len: wkey_len_reg,
                                   occ: 1'b1, live: 1'b1};
        end
        else if (ctl.wr_dead)
        begin
            slot_mem[pos_reg] <= '{bytes: slot_q_reg.bytes, len: slot_q_reg.len,
                                   occ: 1'b1, live: 1'b0};
        end
        else if (ctl.wr_clear_idx || ctl.copy_wr)
        begin
            slot_mem[idx_reg] <= '0;
        end
        if (ctl.slot_rd_pos)
        begin
            slot_q_reg <= slot_mem[pos_reg];
        end
        else if (ctl.slot_rd_idx)
        begin
            slot_q_reg <= slot_mem[idx_reg];
        end
    end

    // Rehash memory
    always_ff @(posedge clk)
    begin
        if (ctl.copy_wr)
        begin
            rh_mem[idx_reg] <= slot_q_reg;
        end
        if (ctl.rh_rd)
        begin
            rh_q_reg <= rh_mem[idx_reg];
        end
    end

    // Key and probe payload
    always_ff @(posedge clk)
    begin
        if (ctl.load_cmd)
        begin
            cmd_reg        <= cmd;
            wkey_bytes_reg <= bytes_masked;
            wkey_len_reg   <= len_sat;
            ckey_bytes_reg <= bytes_masked;
            ckey_len_reg   <= len_sat;
        end
        else if (ctl.load_ckey)
        begin
            wkey_bytes_reg <= ckey_bytes_reg;
            wkey_len_reg   <= ckey_len_reg;
        end
        else if (ctl.load_rkey)
        begin
            wkey_bytes_reg <= rh_q_reg.bytes;
            wkey_len_reg   <= rh_q_reg.len;
        end
        if (ctl.hash)
        begin
            pos_reg  <= pos_next;
            step_reg <= step_next;
            cnt_reg  <= '0;
        end
        else if (ctl.advance)
        begin
            pos_reg <= (pos_reg + step_reg) & mask;
            cnt_reg <= cnt_reg + AW'(1);
        end
        if (ctl.res_set)
        begin
            ok_reg   <= ctl.res_ok;
            full_reg <= ctl.res_full;
        end
    end

    // Control counters and table size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            size_reg   <= CW'(INITIAL_SLOTS);
            active_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (ctl.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (ctl.grow_size)
            begin
                size_reg <= {size_reg[CW-2:0], 1'b0};
            end
            if (ctl.inc_active)
            begin
                active_reg <= active_reg + CW'(1);
            end
            else if (ctl.dec_active)
            begin
                active_reg <= active_reg - CW'(1);
            end
            done_reg <= ctl.res_set;
        end
    end

    // Status
    always_comb
    begin
        sts.cmd           = cmd_reg;
        sts.occ           = slot_q_reg.occ;
        sts.live          = slot_q_reg.live;
        sts.match         = (slot_q_reg.len == wkey_len_reg) &&
                            (slot_q_reg.bytes == wkey_bytes_reg);
        sts.probe_last    = (cnt_reg == mask);
        sts.need_grow     = (active_reg >= (size_reg - (size_reg >> 2)));
        sts.can_grow      = (size_reg <= CW'(MAX_SLOTS / 2));
        sts.idx_last_all  = (idx_reg == {AW{1'b1}});
        sts.idx_last_size = (idx_reg == mask);
        sts.idx_last_half = (idx_reg == AW'((size_reg >> 1) - CW'(1)));
        sts.rh_live       = rh_q_reg.occ && rh_q_reg.live;
    end

    assign done         = done_reg;
    assign success      = ok_reg;
    assign table_full   = full_reg;
    assign live_count   = 11'(active_reg);
    assign slots_in_use = 11'(size_reg);

endmodule

[sv/dhs_controller.sv]
module dhs_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dhs_pkg::sts_t sts,
    output dhs_pkg::ctl_t ctl,
    output logic          busy
);
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECIDE  = 4'd2;
    localparam logic [3:0] S_CP_RD   = 4'd3;
    localparam logic [3:0] S_CP_WR   = 4'd4;
    localparam logic [3:0] S_RH_RD   = 4'd5;
    localparam logic [3:0] S_RH_CHK  = 4'd6;
    localparam logic [3:0] S_RH_NEXT = 4'd7;
    localparam logic [3:0] S_HASH    = 4'd8;
    localparam logic [3:0] S_P_RD    = 4'd9;
    localparam logic [3:0] S_P_CHK   = 4'd10;
    localparam logic [3:0] S_F_RD    = 4'd11;
    localparam logic [3:0] S_F_CHK   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       rh_mode_reg, rh_mode_next;
    logic       is_add;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            rh_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rh_mode_reg <= rh_mode_next;
        end
    end

    assign is_add = (sts.cmd == dhs_pkg::CMD_ADD);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        rh_mode_next = rh_mode_reg;
        ctl          = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.wr_clear_idx = 1'b1;
                if (sts.idx_last_all)
                begin
                    ctl.idx_clr = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load_cmd = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.cmd == dhs_pkg::CMD_ADD)
                begin
                    if (sts.need_grow && !sts.can_grow)
                    begin
                        ctl.res_set  = 1'b1;
                        ctl.res_full = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (sts.need_grow)
                    begin
                        ctl.idx_clr = 1'b1;
                        state_next  = S_CP_RD;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
                else if (sts.cmd inside {dhs_pkg::CMD_FIND, dhs_pkg::CMD_REMOVE})
                begin
                    state_next = S_HASH;
                end
                else
                begin
                    ctl.res_set = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_CP_RD:
            begin
                ctl.slot_rd_idx = 1'b1;
                state_next      = S_CP_WR;
            end
            S_CP_WR:
            begin
                ctl.copy_wr = 1'b1;
                if (sts.idx_last_size)
                begin
                    ctl.grow_size = 1'b1;
                    ctl.idx_clr   = 1'b1;
                    rh_mode_next  = 1'b1;
                    state_next    = S_RH_RD;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_CP_RD;
                end
            end
            S_RH_RD:
            begin
                ctl.rh_rd  = 1'b1;
                state_next = S_RH_CHK;
            end
            S_RH_CHK:
            begin
                if (sts.rh_live)
                begin
                    ctl.load_rkey = 1'b1;
                    state_next    = S_HASH;
                end
                else
                begin
                    state_next = S_RH_NEXT;
                end
            end
            S_RH_NEXT:
            begin
                if (sts.idx_last_half)
                begin
                    ctl.load_ckey = 1'b1;
                    rh_mode_next  = 1'b0;
                    state_next    = S_HASH;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_RH_RD;
                end
            end
            S_HASH:
            begin
                ctl.hash   = 1'b1;
                state_next = S_P_RD;
            end
            S_P_RD:
            begin
                ctl.slot_rd_pos = 1'b1;
                state_next      = S_P_CHK;
            end
            S_P_CHK:
            begin
                if (!sts.occ)
                begin
                    // empty slot ends the probe
                    if (rh_mode_reg)
                    begin
                        ctl.wr_new = 1'b1;
                        state_next = S_RH_NEXT;
                    end
                    else
                    begin
                        ctl.wr_new     = is_add;
                        ctl.inc_active = is_add;
                        ctl.res_set    = 1'b1;
                        ctl.res_ok     = is_add;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.live && sts.match)
                begin
                    if (rh_mode_reg)
                    begin
                        state_next = S_RH_NEXT;
                    end
                    else
                    begin
                        ctl.wr_dead    = (sts.cmd == dhs_pkg::CMD_REMOVE);
                        ctl.dec_active = (sts.cmd == dhs_pkg::CMD_REMOVE);
                        ctl.res_set    = 1'b1;
                        ctl.res_ok     = !is_add;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.probe_last)
                begin
                    // all probes used: add and rehash fall back to the start slot
                    if (rh_mode_reg || is_add)
                    begin
                        ctl.advance = 1'b1;
                        state_next  = S_F_RD;
                    end
                    else
                    begin
                        ctl.res_set = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    ctl.advance = 1'b1;
                    state_next  = S_P_RD;
                end
            end
            S_F_RD:
            begin
                ctl.slot_rd_pos = 1'b1;
                state_next      = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (sts.occ && sts.live)
                begin
                    if (rh_mode_reg)
                    begin
                        state_next = S_RH_NEXT;
                    end
                    else
                    begin
                        ctl.res_set  = 1'b1;
                        ctl.res_full = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    // tombstone reuse
                    ctl.wr_new = 1'b1;
                    if (rh_mode_reg)
                    begin
                        state_next = S_RH_NEXT;
                    end
                    else
                    begin
                        ctl.inc_active = 1'b1;
                        ctl.res_set    = 1'b1;
                        ctl.res_ok     = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[sv/dhs_checker.sv]
`include "double_hash_set_engine_defines.svh"

module dhs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        success,
    input logic        table_full,
    input logic [10:0] live_count,
    input logic [10:0] slots_in_use
);
    // A result never overlaps a running command
    `DHS_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    // A rejected add never reports success
    `DHS_ASSERT_NOW(a_full_excl, clk, rst_n, done && table_full, !success)
    // An accepted command keeps the block busy
    `DHS_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // Table size is a power of two holding all live keys
    `DHS_ASSERT_NOW(a_size_ok, clk, rst_n, done,
        $onehot(slots_in_use) && (live_count <= slots_in_use))

endmodule

bind double_hash_set_engine dhs_checker u_dhs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .success      (success),
    .table_full   (table_full),
    .live_count   (live_count),
    .slots_in_use (slots_in_use)
);
